// ===== sv/ihsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ihsp_pkg
// Types and constants for the image header size parser.
// ----------------------------------------------------------------------------
package ihsp_pkg;

  typedef enum logic [2:0] {
    FMT_UNKNOWN = 3'd0,
    FMT_PNG     = 3'd1,
    FMT_GIF     = 3'd2,
    FMT_JPEG    = 3'd3,
    FMT_WEBP    = 3'd4,
    FMT_BMP     = 3'd5,
    FMT_ICO     = 3'd6
  } fmt_e;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_MARKER = 4'b0010,
    PH_LEN_HI = 4'b0100,
    PH_LEN_LO = 4'b1000
  } phase_e;

  localparam logic [7:0] MarkerPrefix = 8'hFF;
  localparam logic [7:0] MarkerSoi    = 8'hD8;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam logic [7:0] PngMagic     = 8'h89;
  localparam int unsigned HdrUsed     = 30;

  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
  endfunction

endpackage

// ===== sv/ihsp_if.sv =====
// ----------------------------------------------------------------------------
// ihsp_if
// Valid/ready channels for file bytes in and size results out.
// ----------------------------------------------------------------------------
interface ihsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ihsp_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  image_format;
  logic signed [31:0] width_px;
  logic signed [31:0] height_px;

  modport source (output valid, image_format, width_px, height_px, input ready);
  modport sink   (input valid, image_format, width_px, height_px, output ready);
endinterface

// ===== sv/image_header_size_parser_unit.sv =====
// ----------------------------------------------------------------------------
// image_header_size_parser_unit
// Sniffs image format and pixel size from a file streamed one byte per word.
// ----------------------------------------------------------------------------
// One byte word is taken every clock cycle. Each byte is registered, then
// logic updates the position counter, the header capture and the JPEG marker
// walk; on the word flagged last_byte the format, width and height are
// written to the output register as that word leaves the input register,
// and the result word is offered from there. Only the last word of a file
// yields a result. A held result stalls input only when another last word
// reaches it.
module image_header_size_parser_unit #(
  parameter int unsigned OFFSET_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  ihsp_in_if.sink    in_i,
  ihsp_out_if.source out_o
);
  import ihsp_pkg::*;

  localparam int unsigned W = OFFSET_WIDTH;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         adv;

  logic         out_valid_q;
  fmt_e         fmt_q, fmt_d;
  logic [31:0]  wid_q, wid_d, hgt_q, hgt_d;

  logic [7:0]   hdr_q [HdrUsed];
  logic [7:0]   hv [HdrUsed];

  logic [W-1:0] pos_q, pos_d, pos_n;
  logic [W-1:0] nmo_q, nmo_d, nmo_w;
  phase_e       phase_q, phase_d, phase_w;
  logic [15:0]  seglen_q, seglen_d, seglen_w;
  logic         stopped_q, stopped_d, stopped_w;
  logic         found_q, found_d, found_w;
  logic [W-1:0] fofs_q, fofs_d, fofs_w;
  logic [15:0]  fh_q, fh_d, fh_w;
  logic [15:0]  fw_q, fw_d, fw_w;

  logic [W-1:0] dofs;
  logic [15:0]  sl;
  logic [W:0]   sum2, suml;
  logic [W-1:0] jrem;

  assign adv        = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HdrUsed; i++) begin
      if (adv && pos_q == W'(i)) begin
        hdr_q[i] <= in_byte_q;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < HdrUsed; i++) begin
      hv[i] = (pos_q == W'(i)) ? in_byte_q : hdr_q[i];
    end
  end

  assign pos_n = (pos_q != '1) ? pos_q + W'(1) : pos_q;
  assign dofs  = pos_q - fofs_q;
  assign sl    = {seglen_q[15:8], in_byte_q};
  assign sum2  = {1'b0, nmo_q} + (W + 1)'(2);
  assign suml  = {1'b0, nmo_q} + (W + 1)'(17'd2 + {1'b0, sl});

  always_comb begin
    nmo_w     = nmo_q;
    phase_w   = phase_q;
    seglen_w  = seglen_q;
    stopped_w = stopped_q;
    found_w   = found_q;
    fofs_w    = fofs_q;
    fh_w      = fh_q;
    fw_w      = fw_q;
    if (found_q) begin
      if (pos_q >= fofs_q) begin
        if (dofs == W'(5))      fh_w[15:8] = in_byte_q;
        else if (dofs == W'(6)) fh_w[7:0]  = in_byte_q;
        else if (dofs == W'(7)) fw_w[15:8] = in_byte_q;
        else if (dofs == W'(8)) fw_w[7:0]  = in_byte_q;
      end
    end else if (!stopped_q) begin
      unique case (phase_q)
        PH_PREFIX: begin
          if (pos_q == nmo_q) begin
            if (in_byte_q != MarkerPrefix) stopped_w = 1'b1;
            else                           phase_w   = PH_MARKER;
          end
        end
        PH_MARKER: begin
          if (in_byte_q == MarkerSoi || in_byte_q == MarkerEoi) begin
            if (sum2[W]) stopped_w = 1'b1;
            else         nmo_w     = sum2[W-1:0];
            phase_w = PH_PREFIX;
          end else if (is_sof(in_byte_q)) begin
            found_w = 1'b1;
            fofs_w  = nmo_q;
          end else begin
            phase_w = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          seglen_w = {in_byte_q, 8'h00};
          phase_w  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          seglen_w = sl;
          phase_w  = PH_PREFIX;
          if (sl < 16'd2)   stopped_w = 1'b1;
          else if (suml[W]) stopped_w = 1'b1;
          else              nmo_w     = suml[W-1:0];
        end
        default: phase_w = PH_PREFIX;
      endcase
    end
  end

  always_comb begin
    if (in_last_q) begin
      pos_d     = '0;
      nmo_d     = W'(2);
      phase_d   = PH_PREFIX;
      seglen_d  = '0;
      stopped_d = 1'b0;
      found_d   = 1'b0;
      fofs_d    = '0;
      fh_d      = '0;
      fw_d      = '0;
    end else begin
      pos_d     = pos_n;
      nmo_d     = nmo_w;
      phase_d   = phase_w;
      seglen_d  = seglen_w;
      stopped_d = stopped_w;
      found_d   = found_w;
      fofs_d    = fofs_w;
      fh_d      = fh_w;
      fw_d      = fw_w;
    end
  end

  assign jrem = pos_n - fofs_w;

  always_comb begin
    fmt_d = FMT_UNKNOWN;
    wid_d = '0;
    hgt_d = '0;
    priority if (pos_n >= W'(24) && hv[0] == PngMagic && {hv[1], hv[2], hv[3]} == "PNG") begin
      fmt_d = FMT_PNG;
      wid_d = {hv[16], hv[17], hv[18], hv[19]};
      hgt_d = {hv[20], hv[21], hv[22], hv[23]};
    end else if (pos_n >= W'(6) && {hv[0], hv[1], hv[2], hv[3]} == "GIF8" &&
                 (hv[4] == "7" || hv[4] == "9") && hv[5] == "a") begin
      fmt_d = FMT_GIF;
      if (pos_n >= W'(10)) begin
        wid_d = {16'h0, hv[7], hv[6]};
        hgt_d = {16'h0, hv[9], hv[8]};
      end
    end else if (pos_n >= W'(3) && hv[0] == MarkerPrefix && hv[1] == MarkerSoi &&
                 hv[2] == MarkerPrefix) begin
      fmt_d = FMT_JPEG;
      if (found_w && pos_n >= fofs_w && jrem >= W'(10)) begin
        wid_d = {16'h0, fw_w};
        hgt_d = {16'h0, fh_w};
      end
    end else if (pos_n >= W'(30) && {hv[0], hv[1], hv[2], hv[3]} == "RIFF" &&
                 {hv[8], hv[9], hv[10], hv[11]} == "WEBP") begin
      fmt_d = FMT_WEBP;
      if ({hv[12], hv[13], hv[14]} == "VP8") begin
        if (hv[15] == " ") begin
          wid_d = {18'h0, hv[27][5:0], hv[26]};
          hgt_d = {18'h0, hv[29][5:0], hv[28]};
        end else if (hv[15] == "L") begin
          wid_d = 32'd1 + {18'h0, hv[22][5:0], hv[21]};
          hgt_d = 32'd1 + {18'h0, hv[24][3:0], hv[23], hv[22][7:6]};
        end else if (hv[15] == "X") begin
          wid_d = 32'd1 + {8'h0, hv[26], hv[25], hv[24]};
          hgt_d = 32'd1 + {8'h0, hv[29], hv[28], hv[27]};
        end
      end
    end else if (pos_n >= W'(26) && {hv[0], hv[1]} == "BM") begin
      fmt_d = FMT_BMP;
      wid_d = {hv[21], hv[20], hv[19], hv[18]};
      hgt_d = {hv[25], hv[24], hv[23], hv[22]};
    end else if (pos_n >= W'(8) && hv[0] == 8'h00 && hv[1] == 8'h00 &&
                 hv[2] == 8'h01 && hv[3] == 8'h00) begin
      fmt_d = FMT_ICO;
      wid_d = (hv[6] == 8'h00) ? 32'd256 : {24'h0, hv[6]};
      hgt_d = (hv[7] == 8'h00) ? 32'd256 : {24'h0, hv[7]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      nmo_q     <= W'(2);
      phase_q   <= PH_PREFIX;
      seglen_q  <= '0;
      stopped_q <= 1'b0;
      found_q   <= 1'b0;
      fofs_q    <= '0;
      fh_q      <= '0;
      fw_q      <= '0;
    end else if (adv) begin
      pos_q     <= pos_d;
      nmo_q     <= nmo_d;
      phase_q   <= phase_d;
      seglen_q  <= seglen_d;
      stopped_q <= stopped_d;
      found_q   <= found_d;
      fofs_q    <= fofs_d;
      fh_q      <= fh_d;
      fw_q      <= fw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      fmt_q <= fmt_d;
      wid_q <= wid_d;
      hgt_q <= hgt_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.image_format = fmt_q;
  assign out_o.width_px     = wid_q;
  assign out_o.height_px    = hgt_q;

  a_rose_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && in_last_q))
    else $error("result appeared without a last word");

  a_pos_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_last_q) |=> (pos_q == '0 && !found_q && !stopped_q))
    else $error("file state not cleared after last word");

  a_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stopped_q && found_q))
    else $error("walk both stopped and found a frame");

  a_fofs_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (fofs_q >= W'(2) && fofs_q <= nmo_q))
    else $error("frame offset outside walked range");

endmodule
